[rtl/accel_average_and_dominant_frequency_core_defines.svh]
// Assertion macros for the checker file of the average and peak frequency core.
// Depends on nothing; include with the bare file name.
`ifndef ACCEL_AVERAGE_AND_DOMINANT_FREQUENCY_CORE_DEFINES_SVH
`define ACCEL_AVERAGE_AND_DOMINANT_FREQUENCY_CORE_DEFINES_SVH

// Checked property that is ignored while reset is high.
`define ADF_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked property that also holds across reset.
`define ADF_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/adf_pkg.sv]
// Package of the average and peak frequency core: constants, types and the twiddle function.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package adf_pkg;

   localparam int DEF_MA_TAPS     = 10;
   localparam int DEF_FFT_POINTS  = 256;
   localparam int DEF_SAMPLE_BITS = 16;

   localparam int OFF_W     = 16;
   localparam int THR_W     = 24;
   localparam int RATE_W    = 16;
   localparam int CSR_W     = 24;
   localparam int CSR_IDX_W = 2;
   localparam int BIN_OUT_W = 7;
   localparam int FREQ_W    = 23;
   localparam int TW_W      = 18;
   localparam int TW_FRAC   = 17;

   localparam logic [CSR_IDX_W-1:0] CSR_GRAVITY_OFFSET = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PEAK_THRESHOLD = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SAMPLE_RATE    = 2'd2;

   localparam logic signed [OFF_W-1:0] GRAVITY_RESET   = 16'sd4098;
   localparam logic [THR_W-1:0]        THRESHOLD_RESET = 24'd4098;
   localparam logic [RATE_W-1:0]       RATE_RESET      = 16'd104;

   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
   localparam logic [63:0] TW_MAX      = 64'd131071;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIV,
      ST_PEAK_INIT,
      ST_BIN_START,
      ST_RUN,
      ST_DRAIN,
      ST_MAG,
      ST_SQUARE,
      ST_CMP,
      ST_HOLD,
      ST_OUT
   } ctrl_state_type;

   typedef struct packed {
      logic accept;
      logic div_step;
      logic peak_start;
      logic bin_clear;
      logic mac_issue;
      logic mag;
      logic square;
      logic cmp;
      logic hold;
      logic load_out;
   } dp_cmd_type;

   typedef struct packed {
      logic spec_due;
      logic n_last;
      logic pipe_empty;
      logic bin_last;
   } dp_status_type;

   // Quarter-wave sine in Q17 from the Q30 angle, by a nine term Taylor series.
   function automatic logic [TW_W-1:0] tw_q17(input logic [63:0] x);
      logic [63:0] x2;
      logic [63:0] t;
      logic signed [63:0] acc;
      x2  = (x * x) >> 30;
      t   = x;
      acc = signed'(x);
      t   = ((t * x2) >> 30) / 64'd6;
      acc = acc - signed'(t);
      t   = ((t * x2) >> 30) / 64'd20;
      acc = acc + signed'(t);
      t   = ((t * x2) >> 30) / 64'd42;
      acc = acc - signed'(t);
      t   = ((t * x2) >> 30) / 64'd72;
      acc = acc + signed'(t);
      t   = ((t * x2) >> 30) / 64'd110;
      acc = acc - signed'(t);
      t   = ((t * x2) >> 30) / 64'd156;
      acc = acc + signed'(t);
      t   = ((t * x2) >> 30) / 64'd210;
      acc = acc - signed'(t);
      t   = ((t * x2) >> 30) / 64'd272;
      acc = acc + signed'(t);
      if (acc < 0) begin
         acc = 64'sd0;
      end
      acc = (acc + 64'sd4096) >>> 13;
      if (acc > signed'(TW_MAX)) begin
         acc = signed'(TW_MAX);
      end
      return acc[TW_W-1:0];
   endfunction

endpackage
`default_nettype wire

[rtl/adf_if.sv]
// Valid and ready channel interfaces for the sample and result words.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
interface adf_req_if #(parameter int SAMPLE_BITS = 16);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample;
   modport source (output valid, output sample, input ready);
   modport sink (input valid, input sample, output ready);
endinterface

interface adf_rsp_if #(parameter int SAMPLE_BITS = 16);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] average_lsb;
   logic [6:0]                    dominant_bin;
   logic [22:0]                   dominant_freq_scaled;
   logic                          spectrum_done;
   modport source (output valid, output average_lsb, output dominant_bin,
                   output dominant_freq_scaled, output spectrum_done, input ready);
   modport sink (input valid, input average_lsb, input dominant_bin,
                 input dominant_freq_scaled, input spectrum_done, output ready);
endinterface
`default_nettype wire

[rtl/adf_ram.sv]
// Generic simple dual port RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
module adf_ram #(
   parameter int WIDTH = 17,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]              rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

[rtl/adf_datapath.sv]
// Datapath: moving average window, reciprocal divider, spectrum buffer and DFT bin engine.
// Depends on adf_pkg and adf_ram.
`timescale 1ns / 1ps
`default_nettype none
module adf_datapath #(
   parameter int MA_TAPS     = 10,
   parameter int FFT_POINTS  = 256,
   parameter int SAMPLE_BITS = 16
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire adf_pkg::dp_cmd_type             cmd,
   output adf_pkg::dp_status_type               status,
   input  wire logic signed [SAMPLE_BITS-1:0]   sample,
   input  wire logic                            csr_write_en,
   input  wire logic [adf_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [adf_pkg::CSR_W-1:0]       csr_wdata,
   output logic signed [SAMPLE_BITS-1:0]        average_lsb,
   output logic [adf_pkg::BIN_OUT_W-1:0]        dominant_bin,
   output logic [adf_pkg::FREQ_W-1:0]           dominant_freq_scaled,
   output logic                                 spectrum_done
);
   import adf_pkg::*;

   localparam int LOG_N    = $clog2(FFT_POINTS);
   localparam int QUARTER  = FFT_POINTS / 4;
   localparam int TIDX_W   = LOG_N - 1;
   localparam int BIN_W    = LOG_N - 1;
   localparam int SUM_W    = SAMPLE_BITS + $clog2(MA_TAPS);
   localparam int R_W      = $clog2(MA_TAPS);
   localparam int RK       = SUM_W + R_W;
   localparam int PW       = RK + SUM_W;
   localparam logic [PW-1:0] RECIP =
      PW'(((64'd1 << RK) + 64'(MA_TAPS) - 64'd1) / 64'(MA_TAPS));
   localparam int XW       = ((SAMPLE_BITS > OFF_W) ? SAMPLE_BITS : OFF_W) + 1;
   localparam int PROD_W   = XW + TW_W;
   localparam int ACC_W    = PROD_W + LOG_N;
   localparam int MAG_W    = ACC_W - TW_FRAC;
   localparam int SQ_W     = 2 * MAG_W;
   localparam int MSUM_W   = SQ_W + 1;
   localparam int THRSQ_W  = 2 * THR_W;
   localparam int CMP_W    = (MSUM_W > THRSQ_W) ? MSUM_W : THRSQ_W;

   logic [TW_W-1:0] tw_tab [QUARTER+1];

   for (genvar j = 0; j <= QUARTER; j++) begin : g_tw
      localparam logic [63:0] XJ = (HALF_PI_Q30 * 64'(j)) / QUARTER;
      assign tw_tab[j] = tw_q17(XJ);
   end

   function automatic logic signed [TW_W-1:0] tw_at(input logic [LOG_N-1:0] m);
      logic [1:0]              qd;
      logic [TIDX_W-1:0]       fw;
      logic [TIDX_W-1:0]       bw;
      logic signed [TW_W-1:0]  pf;
      logic signed [TW_W-1:0]  pb;
      qd = m[LOG_N-1:LOG_N-2];
      fw = TIDX_W'(m[LOG_N-3:0]);
      bw = TIDX_W'(QUARTER) - fw;
      pf = signed'(tw_tab[fw]);
      pb = signed'(tw_tab[bw]);
      case (qd)
         2'd0:    return pb;
         2'd1:    return -pf;
         2'd2:    return -pb;
         default: return pf;
      endcase
   endfunction

   logic signed [OFF_W-1:0]       gravity_ff, gravity_in;
   logic [THR_W-1:0]              thr_ff, thr_in;
   logic [RATE_W-1:0]             rate_ff, rate_in;
   logic signed [SAMPLE_BITS-1:0] ring_ff [MA_TAPS];
   logic signed [SAMPLE_BITS-1:0] ring_in [MA_TAPS];
   logic signed [SUM_W-1:0]       sum_ff, sum_in;
   logic [LOG_N-1:0]              fill_ff, fill_in;
   logic                          due_ff, due_in;
   logic [SUM_W-1:0]              dq_ff, dq_in;
   logic                          neg_ff, neg_in;
   logic [LOG_N-1:0]              n_ff, n_in;
   logic [LOG_N-1:0]              phase_ff, phase_in;
   logic [BIN_W-1:0]              bin_ff, bin_in;
   logic                          v1_ff, v1_in;
   logic [LOG_N-1:0]              ph1_ff, ph1_in;
   logic                          v2_ff, v2_in;
   logic signed [XW-1:0]          x2_ff, x2_in;
   logic signed [TW_W-1:0]        cos2_ff, cos2_in;
   logic signed [TW_W-1:0]        sin2_ff, sin2_in;
   logic                          v3_ff, v3_in;
   logic signed [PROD_W-1:0]      pre_ff, pre_in;
   logic signed [PROD_W-1:0]      pim_ff, pim_in;
   logic signed [ACC_W-1:0]       are_ff, are_in;
   logic signed [ACC_W-1:0]       aim_ff, aim_in;
   logic [MAG_W-1:0]              mre_ff, mre_in;
   logic [MAG_W-1:0]              mim_ff, mim_in;
   logic [SQ_W-1:0]               sre_ff, sre_in;
   logic [SQ_W-1:0]               sim_ff, sim_in;
   logic [MSUM_W-1:0]             best_ff, best_in;
   logic [BIN_W-1:0]              bbin_ff, bbin_in;
   logic [THRSQ_W-1:0]            thrsq_ff, thrsq_in;
   logic [BIN_OUT_W-1:0]          held_ff, held_in;
   logic signed [SAMPLE_BITS-1:0] avg_ff, avg_in;
   logic [BIN_OUT_W-1:0]          obin_ff, obin_in;
   logic [FREQ_W-1:0]             ofreq_ff, ofreq_in;
   logic                          odone_ff, odone_in;

   logic signed [SUM_W-1:0]       s_ext;
   logic signed [SUM_W-1:0]       new_sum;
   logic signed [XW-1:0]          x_wr;
   logic [XW-1:0]                 x_rd;
   logic [PW-1:0]                 div_prod;
   logic [SUM_W-1:0]              quot;
   logic signed [ACC_W-1:0]       abs_re;
   logic signed [ACC_W-1:0]       abs_im;
   logic [MSUM_W-1:0]             msum;
   logic [31:0]                   bbin_wide;
   logic [LOG_N-1:0]              ph_sin;

   adf_ram #(.WIDTH(XW), .DEPTH(FFT_POINTS)) u_spec_ram (
      .clock   (clock),
      .wr_en   (cmd.accept),
      .wr_addr (fill_ff),
      .wr_data (x_wr),
      .rd_addr (n_ff),
      .rd_data (x_rd)
   );

   always_comb begin
      s_ext     = SUM_W'(sample);
      new_sum   = sum_ff - SUM_W'(ring_ff[MA_TAPS-1]) + s_ext;
      x_wr      = XW'(sample) - XW'(gravity_ff);
      div_prod  = PW'(dq_ff) * RECIP;
      quot      = neg_ff ? -dq_ff : dq_ff;
      abs_re    = are_ff[ACC_W-1] ? -are_ff : are_ff;
      abs_im    = aim_ff[ACC_W-1] ? -aim_ff : aim_ff;
      msum      = MSUM_W'(sre_ff) + MSUM_W'(sim_ff);
      bbin_wide = 32'(bbin_ff);
      ph_sin    = ph1_ff + LOG_N'(3 * QUARTER);

      gravity_in = gravity_ff;
      thr_in     = thr_ff;
      rate_in    = rate_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_GRAVITY_OFFSET: gravity_in = signed'(csr_wdata[OFF_W-1:0]);
            CSR_PEAK_THRESHOLD: thr_in     = csr_wdata[THR_W-1:0];
            CSR_SAMPLE_RATE:    rate_in    = csr_wdata[RATE_W-1:0];
            default: ;
         endcase
      end

      ring_in = ring_ff;
      sum_in  = sum_ff;
      fill_in = fill_ff;
      due_in  = due_ff;
      dq_in   = dq_ff;
      neg_in  = neg_ff;
      if (cmd.accept) begin
         ring_in[0] = sample;
         for (int i = 1; i < MA_TAPS; i++) begin
            ring_in[i] = ring_ff[i-1];
         end
         sum_in  = new_sum;
         fill_in = fill_ff + 1'b1;
         due_in  = fill_ff == LOG_N'(FFT_POINTS - 1);
         neg_in  = new_sum[SUM_W-1];
         dq_in   = new_sum[SUM_W-1] ? -new_sum : new_sum;
      end else if (cmd.div_step) begin
         dq_in = div_prod[RK +: SUM_W];
      end

      n_in     = n_ff;
      phase_in = phase_ff;
      if (cmd.bin_clear) begin
         n_in     = '0;
         phase_in = '0;
      end else if (cmd.mac_issue) begin
         n_in     = n_ff + 1'b1;
         phase_in = phase_ff + LOG_N'(bin_ff);
      end

      v1_in   = cmd.mac_issue;
      ph1_in  = phase_ff;
      v2_in   = v1_ff;
      x2_in   = signed'(x_rd);
      cos2_in = tw_at(ph1_ff);
      sin2_in = tw_at(ph_sin);
      v3_in   = v2_ff;
      pre_in  = x2_ff * cos2_ff;
      pim_in  = x2_ff * sin2_ff;

      are_in = are_ff;
      aim_in = aim_ff;
      if (cmd.bin_clear) begin
         are_in = '0;
         aim_in = '0;
      end else if (v3_ff) begin
         are_in = are_ff + ACC_W'(pre_ff);
         aim_in = aim_ff + ACC_W'(pim_ff);
      end

      mre_in = cmd.mag ? abs_re[ACC_W-1:TW_FRAC] : mre_ff;
      mim_in = cmd.mag ? abs_im[ACC_W-1:TW_FRAC] : mim_ff;
      sre_in = cmd.square ? SQ_W'(mre_ff) * SQ_W'(mre_ff) : sre_ff;
      sim_in = cmd.square ? SQ_W'(mim_ff) * SQ_W'(mim_ff) : sim_ff;

      bin_in   = bin_ff;
      best_in  = best_ff;
      bbin_in  = bbin_ff;
      thrsq_in = thrsq_ff;
      if (cmd.peak_start) begin
         bin_in   = BIN_W'(1);
         best_in  = '0;
         bbin_in  = '0;
         thrsq_in = THRSQ_W'(thr_ff) * THRSQ_W'(thr_ff);
      end else if (cmd.cmp) begin
         bin_in = bin_ff + 1'b1;
         if (CMP_W'(msum) > CMP_W'(best_ff)) begin
            best_in = msum;
            bbin_in = bin_ff;
         end
      end

      held_in = held_ff;
      if (cmd.hold) begin
         held_in = (CMP_W'(best_ff) > CMP_W'(thrsq_ff)) ? bbin_wide[BIN_OUT_W-1:0] : '0;
      end

      avg_in   = avg_ff;
      obin_in  = obin_ff;
      ofreq_in = ofreq_ff;
      odone_in = odone_ff;
      if (cmd.load_out) begin
         avg_in   = signed'(quot[SAMPLE_BITS-1:0]);
         obin_in  = held_ff;
         ofreq_in = FREQ_W'(held_ff) * FREQ_W'(rate_ff);
         odone_in = due_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gravity_ff <= GRAVITY_RESET;
         thr_ff     <= THRESHOLD_RESET;
         rate_ff    <= RATE_RESET;
         for (int i = 0; i < MA_TAPS; i++) begin
            ring_ff[i] <= '0;
         end
         sum_ff  <= '0;
         fill_ff <= '0;
         due_ff  <= 1'b0;
         held_ff <= '0;
         v1_ff   <= 1'b0;
         v2_ff   <= 1'b0;
         v3_ff   <= 1'b0;
      end else begin
         gravity_ff <= gravity_in;
         thr_ff     <= thr_in;
         rate_ff    <= rate_in;
         ring_ff    <= ring_in;
         sum_ff     <= sum_in;
         fill_ff    <= fill_in;
         due_ff     <= due_in;
         held_ff    <= held_in;
         v1_ff      <= v1_in;
         v2_ff      <= v2_in;
         v3_ff      <= v3_in;
      end
   end

   always_ff @(posedge clock) begin
      dq_ff    <= dq_in;
      neg_ff   <= neg_in;
      n_ff     <= n_in;
      phase_ff <= phase_in;
      bin_ff   <= bin_in;
      ph1_ff   <= ph1_in;
      x2_ff    <= x2_in;
      cos2_ff  <= cos2_in;
      sin2_ff  <= sin2_in;
      pre_ff   <= pre_in;
      pim_ff   <= pim_in;
      are_ff   <= are_in;
      aim_ff   <= aim_in;
      mre_ff   <= mre_in;
      mim_ff   <= mim_in;
      sre_ff   <= sre_in;
      sim_ff   <= sim_in;
      best_ff  <= best_in;
      bbin_ff  <= bbin_in;
      thrsq_ff <= thrsq_in;
      avg_ff   <= avg_in;
      obin_ff  <= obin_in;
      ofreq_ff <= ofreq_in;
      odone_ff <= odone_in;
   end

   assign status.spec_due   = due_ff;
   assign status.n_last     = n_ff == LOG_N'(FFT_POINTS - 1);
   assign status.pipe_empty = !v1_ff && !v2_ff && !v3_ff;
   assign status.bin_last   = bin_ff == BIN_W'(FFT_POINTS / 2 - 1);

   assign average_lsb          = avg_ff;
   assign dominant_bin         = obin_ff;
   assign dominant_freq_scaled = ofreq_ff;
   assign spectrum_done        = odone_ff;
endmodule
`default_nettype wire

[rtl/adf_ctrl.sv]
// Controller state machine that sequences the datapath and owns both handshakes.
// Depends on adf_pkg.
`timescale 1ns / 1ps
`default_nettype none
module adf_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output adf_pkg::dp_cmd_type         cmd,
   input  wire adf_pkg::dp_status_type status
);
   import adf_pkg::*;

   ctrl_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      req_ready    = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            state_in     = status.spec_due ? ST_PEAK_INIT : ST_OUT;
         end
         ST_PEAK_INIT: begin
            cmd.peak_start = 1'b1;
            state_in       = ST_BIN_START;
         end
         ST_BIN_START: begin
            cmd.bin_clear = 1'b1;
            state_in      = ST_RUN;
         end
         ST_RUN: begin
            cmd.mac_issue = 1'b1;
            if (status.n_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (status.pipe_empty) begin
               state_in = ST_MAG;
            end
         end
         ST_MAG: begin
            cmd.mag  = 1'b1;
            state_in = ST_SQUARE;
         end
         ST_SQUARE: begin
            cmd.square = 1'b1;
            state_in   = ST_CMP;
         end
         ST_CMP: begin
            cmd.cmp  = 1'b1;
            state_in = status.bin_last ? ST_HOLD : ST_BIN_START;
         end
         ST_HOLD: begin
            cmd.hold = 1'b1;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
endmodule
`default_nettype wire

[rtl/accel_average_and_dominant_frequency_core.sv]
// Top level of the moving average and dominant frequency core.
// Depends on adf_pkg, adf_if, adf_ctrl and adf_datapath.
//
//   channel   direction  contents
//   req_chan  in         one sample word
//   rsp_chan  out        average, held bin, held frequency, spectrum flag
//   csr_*     in         register writes, no read-back
//
// A sample passes through the accept, one reciprocal multiply that forms the
// average, and the load of the result word, which waits until the sink has taken any earlier word.
// A sample that completes a spectrum adds the peak setup, FFT_POINTS/2 - 1 bins worked one after
// another by the single multiply-accumulate bin engine, and the hold of the peak bin.
// Reset is synchronous and clears the window, the fill count and the held bin.
// The next sample is taken while a result word still waits for the sink; its own word then waits.
`timescale 1ns / 1ps
`default_nettype none
module accel_average_and_dominant_frequency_core #(
   parameter int MA_TAPS     = adf_pkg::DEF_MA_TAPS,
   parameter int FFT_POINTS  = adf_pkg::DEF_FFT_POINTS,
   parameter int SAMPLE_BITS = adf_pkg::DEF_SAMPLE_BITS
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   adf_req_if.sink                            req_chan,
   adf_rsp_if.source                          rsp_chan,
   input  wire logic                          csr_write_en,
   input  wire logic [adf_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [adf_pkg::CSR_W-1:0]     csr_wdata
);
   import adf_pkg::*;

   dp_cmd_type                    cmd;
   dp_status_type                 status;
   logic signed [SAMPLE_BITS-1:0] average;

   adf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd),
      .status    (status)
   );

   adf_datapath #(
      .MA_TAPS     (MA_TAPS),
      .FFT_POINTS  (FFT_POINTS),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_datapath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .status               (status),
      .sample               (req_chan.sample),
      .csr_write_en         (csr_write_en),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata),
      .average_lsb          (average),
      .dominant_bin         (rsp_chan.dominant_bin),
      .dominant_freq_scaled (rsp_chan.dominant_freq_scaled),
      .spectrum_done        (rsp_chan.spectrum_done)
   );

   assign rsp_chan.average_lsb = average;
endmodule
`default_nettype wire

[rtl/adf_checker.sv]
// Port-level checker for the average and dominant frequency core, bound to the top level.
// Depends on the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "accel_average_and_dominant_frequency_core_defines.svh"
module adf_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [6:0]  dominant_bin,
   input wire logic [22:0] dominant_freq_scaled
);
   `ADF_ASSERT_ALWAYS(a_no_word_after_reset, clock, reset |=> !rsp_valid, "result word after reset")
   `ADF_ASSERT(a_busy_after_accept, clock, reset, req_valid && req_ready |=> !req_ready, "second word taken while busy")
   `ADF_ASSERT(a_zero_bin_zero_freq, clock, reset, rsp_valid && dominant_bin == 7'd0 |-> dominant_freq_scaled == 23'd0, "nonzero frequency for bin zero")
   `ADF_ASSERT(a_rsp_held, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid, "result word dropped while stalled")
endmodule

bind accel_average_and_dominant_frequency_core adf_checker u_adf_checker (
   .clock                (clock),
   .reset                (reset),
   .req_valid            (req_chan.valid),
   .req_ready            (req_chan.ready),
   .rsp_valid            (rsp_chan.valid),
   .rsp_ready            (rsp_chan.ready),
   .dominant_bin         (rsp_chan.dominant_bin),
   .dominant_freq_scaled (rsp_chan.dominant_freq_scaled)
);
`default_nettype wire
